/* hw/rtl/three_level_weighted_run_queue_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the three-level weighted run queue.
// Concurrent checks are compiled out in synthesis.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_WEIGHTED_RUN_QUEUE_MACROS_SVH
`define THREE_LEVEL_WEIGHTED_RUN_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Check that is disabled while reset is asserted.
`define TWRQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("twrq: check failed");
// Check that must hold at every clock edge, reset included.
`define TWRQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("twrq: check failed");
`else
`define TWRQ_ASSERT(name, clk, rst_n, prop)
`define TWRQ_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* hw/rtl/twrq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twrq_pkg
// Shared types and constants of the three-level weighted run queue.
// ----------------------------------------------------------------------------
package twrq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;
  localparam int DEFAULT_ID_WIDTH    = 16;
  localparam int ADV_WIDTH           = 8;
  localparam int NUM_QUEUES          = 3;
  localparam logic [ADV_WIDTH-1:0] ADVANTAGE_RESET = 8'd8;

  // Queue codes, also used as priority codes of an enqueue.
  typedef enum logic [1:0] {
    QUEUE_LOW    = 2'd0,
    QUEUE_NORMAL = 2'd1,
    QUEUE_HIGH   = 2'd2
  } queue_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ACTION_ENQUEUE = 1'b0,
    ACTION_SELECT  = 1'b1
  } action_e;

  // Per-transaction control from the scheduler to the queues and result stage.
  typedef struct packed {
    logic [NUM_QUEUES-1:0] push;
    logic [NUM_QUEUES-1:0] pop;
    logic                  grant;
    status_e               status;
    queue_e                queue;
  } sched_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/twrq_item_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twrq_item_if
// Request channel: enqueue a task id or select the next task.
// ----------------------------------------------------------------------------
interface twrq_item_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic                action;
  logic [1:0]          priority_req;
  logic [ID_WIDTH-1:0] task_id;

  modport source (output valid, action, priority_req, task_id, input ready);
  modport sink   (input valid, action, priority_req, task_id, output ready);
endinterface
`default_nettype wire

/* hw/rtl/twrq_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twrq_result_if
// Result channel: status and granted task of each request.
// ----------------------------------------------------------------------------
interface twrq_result_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [ID_WIDTH-1:0] granted_id;
  logic [1:0]          granted_queue;

  modport source (output valid, status, granted_id, granted_queue, input ready);
  modport sink   (input valid, status, granted_id, granted_queue, output ready);
endinterface
`default_nettype wire

/* hw/rtl/twrq_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twrq_cfg_if
// Configuration write channel for the advantage limit.
// ----------------------------------------------------------------------------
interface twrq_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] advantage_limit;

  modport source (output valid, advantage_limit, input ready);
  modport sink   (input valid, advantage_limit, output ready);
endinterface
`default_nettype wire

/* hw/rtl/three_level_weighted_run_queue.sv */
// Path: an accepted request waits in the input register and then goes to the
// result register once that register is empty or its result is taken.
// Throughput: one request per cycle while results are taken, set by the
// single-pass decision and the one-write, one-read port of each queue memory.
// Reset: queues empty, advantage counter zero, limit 8; no clearing pass.
`default_nettype none
`include "three_level_weighted_run_queue_macros.svh"
// ----------------------------------------------------------------------------
// three_level_weighted_run_queue
// Three FIFO run queues of task ids with strict high and weighted normal/low.
// ----------------------------------------------------------------------------
module three_level_weighted_run_queue
  import twrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int ID_WIDTH    = DEFAULT_ID_WIDTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  twrq_item_if.sink     item_i,
  twrq_result_if.source result_o,
  twrq_cfg_if.sink      cfg_i
);
  logic [ADV_WIDTH-1:0] limit_q;

  logic                 in_valid_q;
  logic                 action_q;
  logic [1:0]           priority_q;
  logic [ID_WIDTH-1:0]  id_q;

  logic                 out_valid_q;
  logic                 grant_q;
  status_e              status_q;
  queue_e               queue_q;

  logic                 advance, fire;
  sched_ctl_t           ctl;
  logic [NUM_QUEUES-1:0] empty, full;
  logic [ID_WIDTH-1:0]  rdata [NUM_QUEUES];

  // Configuration register, always writable.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ADVANTAGE_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.advantage_limit;
    end
  end

  // Pipeline control: the result register frees up when empty or taken.
  assign advance      = !out_valid_q || result_o.ready;
  assign fire         = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.valid && item_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      action_q   <= item_i.action;
      priority_q <= item_i.priority_req;
      id_q       <= item_i.task_id;
    end
  end

  // Scheduling decision for the held transaction.
  twrq_sched u_sched (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .action_i       (action_q),
    .priority_req_i (priority_q),
    .empty_i        (empty),
    .full_i         (full),
    .limit_i        (limit_q),
    .ctl_o          (ctl)
  );

  // One run queue per priority level, indexed by queue code.
  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
    twrq_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ID_WIDTH)
    ) u_fifo (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .push_i  (ctl.push[g]),
      .pop_i   (ctl.pop[g]),
      .wdata_i (id_q),
      .rdata_o (rdata[g]),
      .empty_o (empty[g]),
      .full_o  (full[g])
    );
  end

  // Result register; the granted id sits in the popped queue's read register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      grant_q  <= ctl.grant;
      status_q <= ctl.status;
      queue_q  <= ctl.queue;
    end
  end

  // Result channel outputs.
  always_comb begin
    result_o.valid         = out_valid_q;
    result_o.status        = status_q;
    result_o.granted_queue = queue_q;
    result_o.granted_id    = '0;
    if (grant_q) begin
      case (queue_q)
        QUEUE_HIGH:   result_o.granted_id = rdata[QUEUE_HIGH];
        QUEUE_NORMAL: result_o.granted_id = rdata[QUEUE_NORMAL];
        default:      result_o.granted_id = rdata[QUEUE_LOW];
      endcase
    end
  end

  // At most one queue is written or read per transaction.
  `TWRQ_ASSERT_ALWAYS(a_one_pop, clk_i, $onehot0(ctl.pop) && $onehot0(ctl.push))
  // A pop never hits an empty queue.
  `TWRQ_ASSERT(a_no_underflow, clk_i, rst_ni, (ctl.pop & empty) == '0)
  // A push never hits a full queue.
  `TWRQ_ASSERT(a_no_overflow, clk_i, rst_ni, (ctl.push & full) == '0)
  // A granted result always reports success.
  `TWRQ_ASSERT(a_grant_ok, clk_i, rst_ni, (out_valid_q && grant_q) |-> (status_q == STATUS_OK))

endmodule
`default_nettype wire

/* hw/rtl/twrq_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twrq_fifo
// One run queue: circular id memory with head, tail and fill count.
// ----------------------------------------------------------------------------
module twrq_fifo
  import twrq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int WIDTH = DEFAULT_ID_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             pop_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FULL_CNT);
  assign rdata_o = rdata_q;

  // Pointer and count update, with wrap at the last entry.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
      count_d = count_d + 1'b1;
    end
    if (pop_i) begin
      head_d  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
      count_d = count_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Id storage; the head entry is read into a register on a pop and held.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/twrq_sched.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twrq_sched
// Strict high priority plus weighted normal/low choice, with advantage counter.
// ----------------------------------------------------------------------------
module twrq_sched
  import twrq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  action_i,
  input  logic [1:0]            priority_req_i,
  input  logic [NUM_QUEUES-1:0] empty_i,
  input  logic [NUM_QUEUES-1:0] full_i,
  input  logic [ADV_WIDTH-1:0]  limit_i,
  output sched_ctl_t            ctl_o
);
  logic [ADV_WIDTH-1:0] counter_q, counter_d;
  queue_e               target;
  queue_e               first_q, second_q;
  logic                 prefer_normal;

  // Enqueue target; any code other than normal or high means low.
  always_comb begin
    if (priority_req_i == QUEUE_NORMAL) begin
      target = QUEUE_NORMAL;
    end else if (priority_req_i == QUEUE_HIGH) begin
      target = QUEUE_HIGH;
    end else begin
      target = QUEUE_LOW;
    end
  end

  assign prefer_normal = (counter_q < limit_i);
  assign first_q       = prefer_normal ? QUEUE_NORMAL : QUEUE_LOW;
  assign second_q      = prefer_normal ? QUEUE_LOW : QUEUE_NORMAL;

  // Decision for the transaction held in the input register.
  always_comb begin
    ctl_o        = '0;
    ctl_o.status = STATUS_OK;
    ctl_o.queue  = QUEUE_LOW;
    counter_d    = counter_q;
    if (action_i == ACTION_ENQUEUE) begin
      if (full_i[target]) begin
        ctl_o.status = STATUS_FULL;
      end else begin
        ctl_o.push[target] = fire_i;
      end
    end else if (!empty_i[QUEUE_HIGH]) begin
      ctl_o.pop[QUEUE_HIGH] = fire_i;
      ctl_o.grant           = 1'b1;
      ctl_o.queue           = QUEUE_HIGH;
    end else begin
      if (fire_i) begin
        counter_d = prefer_normal ? counter_q + 1'b1 : '0;
      end
      if (!empty_i[first_q]) begin
        ctl_o.pop[first_q] = fire_i;
        ctl_o.grant        = 1'b1;
        ctl_o.queue        = first_q;
      end else if (!empty_i[second_q]) begin
        ctl_o.pop[second_q] = fire_i;
        ctl_o.grant         = 1'b1;
        ctl_o.queue         = second_q;
      end else begin
        ctl_o.status = STATUS_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
    end else begin
      counter_q <= counter_d;
    end
  end

endmodule
`default_nettype wire
